/* rtl/core/pewm_pkg.sv */
// Shared types and constants for the pointer edge wrap mapper.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps

package pewm_pkg;

   // Fixed port widths
   localparam int OUT_W      = 16;
   localparam int SLOT_W     = 3;
   localparam int COUNT_W    = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Command opcodes
   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   // Configuration register indexes (byte address / 4)
   typedef enum logic [1:0] {
      CSR_MONITOR_COUNT = 2'd0,
      CSR_WRAP_H        = 2'd1,
      CSR_WRAP_V        = 2'd2
   } csr_index_type;

   // Query token control travelling down the cell chain
   typedef struct packed {
      logic valid;     // a query occupies this stage
      logic row_hit;   // some monitor covers the query row
      logic col_hit;   // some monitor covers the query column
   } pewm_tok_type;

endpackage

/* rtl/core/pewm_cell.sv */
// One cell of the monitor chain: holds one rectangle and folds it into the
// row and column edge reductions of the query passing through.
// Depends on pewm_pkg.
`timescale 1ns / 1ps

module pewm_cell
   import pewm_pkg::*;
#(
   parameter int COORD_W = 16
) (
   input  logic               clock,
   input  logic               reset,
   // rectangle load
   input  logic               load_en,
   input  logic [COORD_W-1:0] load_left,
   input  logic [COORD_W-1:0] load_top,
   input  logic [COORD_W-1:0] load_right,
   input  logic [COORD_W-1:0] load_bottom,
   // slot takes part in queries
   input  logic               active,
   // query from upstream neighbor
   input  pewm_tok_type       up_tok,
   input  logic [COORD_W-1:0] up_x,
   input  logic [COORD_W-1:0] up_y,
   input  logic [COORD_W-1:0] up_row_lo,
   input  logic [COORD_W-1:0] up_row_hi,
   input  logic [COORD_W-1:0] up_col_lo,
   input  logic [COORD_W-1:0] up_col_hi,
   // query to downstream neighbor
   output pewm_tok_type       dn_tok,
   output logic [COORD_W-1:0] dn_x,
   output logic [COORD_W-1:0] dn_y,
   output logic [COORD_W-1:0] dn_row_lo,
   output logic [COORD_W-1:0] dn_row_hi,
   output logic [COORD_W-1:0] dn_col_lo,
   output logic [COORD_W-1:0] dn_col_hi
);

   logic [COORD_W-1:0] left_ff, top_ff, right_ff, bottom_ff;
   pewm_tok_type       tok_ff, tok_in;
   logic [COORD_W-1:0] x_ff, y_ff;
   logic [COORD_W-1:0] row_lo_ff, row_lo_in, row_hi_ff, row_hi_in;
   logic [COORD_W-1:0] col_lo_ff, col_lo_in, col_hi_ff, col_hi_in;
   logic               row_cov, col_cov;

   // Rectangle storage
   always_ff @(posedge clock) begin
      if (load_en) begin
         left_ff   <= load_left;
         top_ff    <= load_top;
         right_ff  <= load_right;
         bottom_ff <= load_bottom;
      end
   end

   // Coverage of the query row and column by this rectangle
   assign row_cov = active && (up_y >= top_ff) && (up_y < bottom_ff);
   assign col_cov = active && (up_x >= left_ff) && (up_x < right_ff);

   // Fold this rectangle into the running min / max edges
   always_comb begin
      tok_in         = up_tok;
      tok_in.row_hit = up_tok.row_hit | row_cov;
      tok_in.col_hit = up_tok.col_hit | col_cov;

      row_lo_in = up_row_lo;
      row_hi_in = up_row_hi;
      if (row_cov && (!up_tok.row_hit || left_ff < up_row_lo)) begin
         row_lo_in = left_ff;
      end
      if (row_cov && (!up_tok.row_hit || right_ff > up_row_hi)) begin
         row_hi_in = right_ff;
      end

      col_lo_in = up_col_lo;
      col_hi_in = up_col_hi;
      if (col_cov && (!up_tok.col_hit || top_ff < up_col_lo)) begin
         col_lo_in = top_ff;
      end
      if (col_cov && (!up_tok.col_hit || bottom_ff > up_col_hi)) begin
         col_hi_in = bottom_ff;
      end
   end

   // Token control
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   // Token payload
   always_ff @(posedge clock) begin
      x_ff      <= up_x;
      y_ff      <= up_y;
      row_lo_ff <= row_lo_in;
      row_hi_ff <= row_hi_in;
      col_lo_ff <= col_lo_in;
      col_hi_ff <= col_hi_in;
   end

   assign dn_tok    = tok_ff;
   assign dn_x      = x_ff;
   assign dn_y      = y_ff;
   assign dn_row_lo = row_lo_ff;
   assign dn_row_hi = row_hi_ff;
   assign dn_col_lo = col_lo_ff;
   assign dn_col_hi = col_hi_ff;

endmodule

/* rtl/core/pewm_wrap.sv */
// Tail of the chain: compares the pointer against the reduced edges,
// applies wrapping and registers the result strobe.
// Depends on pewm_pkg.
`timescale 1ns / 1ps

module pewm_wrap
   import pewm_pkg::*;
#(
   parameter int COORD_W = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wrap_h,
   input  logic               wrap_v,
   input  pewm_tok_type       tok,
   input  logic [COORD_W-1:0] x,
   input  logic [COORD_W-1:0] y,
   input  logic [COORD_W-1:0] row_lo,
   input  logic [COORD_W-1:0] row_hi,
   input  logic [COORD_W-1:0] col_lo,
   input  logic [COORD_W-1:0] col_hi,
   output logic               strobe,
   output logic [OUT_W-1:0]   mapped_x,
   output logic [OUT_W-1:0]   mapped_y,
   output logic [1:0]         wrap_count
);

   logic               strobe_ff;
   logic [OUT_W-1:0]   mapped_x_ff, mapped_x_in, mapped_y_ff, mapped_y_in;
   logic [1:0]         wrap_count_ff, wrap_count_in;
   logic [COORD_W-1:0] row_edge, col_edge, nx, ny;
   logic               hwrap, vwrap;

   // Right / bottom edge is the exclusive end minus one; an end of zero
   // wraps to all ones, so the compare below skips the edge for a zero end.
   assign row_edge = row_hi - COORD_W'(1);
   assign col_edge = col_hi - COORD_W'(1);

   always_comb begin
      nx    = x;
      ny    = y;
      hwrap = 1'b0;
      vwrap = 1'b0;
      if (wrap_h && tok.row_hit) begin
         if (x == row_lo) begin
            nx    = row_edge;
            hwrap = 1'b1;
         end else if ((row_hi != '0) && (x == row_edge)) begin
            nx    = row_lo;
            hwrap = 1'b1;
         end
      end
      if (wrap_v && tok.col_hit) begin
         if (y == col_lo) begin
            ny    = col_edge;
            vwrap = 1'b1;
         end else if ((col_hi != '0) && (y == col_edge)) begin
            ny    = col_lo;
            vwrap = 1'b1;
         end
      end
      mapped_x_in   = OUT_W'(nx);
      mapped_y_in   = OUT_W'(ny);
      wrap_count_in = {1'b0, hwrap} + {1'b0, vwrap};
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tok.valid;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      mapped_x_ff   <= mapped_x_in;
      mapped_y_ff   <= mapped_y_in;
      wrap_count_ff <= wrap_count_in;
   end

   assign strobe     = strobe_ff;
   assign mapped_x   = mapped_x_ff;
   assign mapped_y   = mapped_y_ff;
   assign wrap_count = wrap_count_ff;

endmodule

/* rtl/core/pointer_edge_wrap_mapper.sv */
// Top level of the pointer edge wrap mapper: command port, register file,
// the monitor cell chain and the wrap unit.
// Depends on pewm_pkg, pewm_cell and pewm_wrap.
`timescale 1ns / 1ps

// A load transaction (opcode 0) writes one monitor slot and produces no
// result; busy stays low, so the next transaction can start in the
// following cycle. A query transaction (opcode 1) walks a chain of
// MONITOR_SLOTS cells, one cell per clock, and then the wrap unit; its
// result is on the rsp_ ports, marked by rsp_strobe, for one cycle, after
// the cell registers and the wrap unit's result register. busy rises in
// the cycle after the query starts and stays high until the strobe cycle
// ends, so no new transaction is accepted before the last result is out.
// The result cannot be held off and must be taken in its strobe cycle.
// The user must write registers over the APB port only while no query
// is in flight; the block itself does not enforce this.
module pointer_edge_wrap_mapper
   import pewm_pkg::*;
#(
   parameter int MONITOR_SLOTS = 8,
   parameter int COORD_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // command channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_opcode,
   input  logic [SLOT_W-1:0]     req_slot,
   input  logic [15:0]           req_rect_left,
   input  logic [15:0]           req_rect_top,
   input  logic [15:0]           req_rect_right,
   input  logic [15:0]           req_rect_bottom,
   input  logic [15:0]           req_pointer_x,
   input  logic [15:0]           req_pointer_y,
   // result channel
   output logic                  rsp_strobe,
   output logic [OUT_W-1:0]      rsp_mapped_x,
   output logic [OUT_W-1:0]      rsp_mapped_y,
   output logic [1:0]            rsp_wrap_count,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CW = COORD_BITS;

   logic               accept, load_go, query_go;
   logic               busy_ff, busy_in;
   logic [COUNT_W-1:0] monitor_count_ff;
   logic               wrap_h_ff, wrap_v_ff;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [CW-1:0]      ld_left, ld_top, ld_right, ld_bottom;

   pewm_tok_type  tok_chain    [MONITOR_SLOTS+1];
   logic [CW-1:0] x_chain      [MONITOR_SLOTS+1];
   logic [CW-1:0] y_chain      [MONITOR_SLOTS+1];
   logic [CW-1:0] row_lo_chain [MONITOR_SLOTS+1];
   logic [CW-1:0] row_hi_chain [MONITOR_SLOTS+1];
   logic [CW-1:0] col_lo_chain [MONITOR_SLOTS+1];
   logic [CW-1:0] col_hi_chain [MONITOR_SLOTS+1];

   // Command handshake
   assign accept   = start && !busy_ff;
   assign load_go  = accept && (req_opcode == OP_LOAD);
   assign query_go = accept && (req_opcode == OP_QUERY);

   // Busy from query start through the result strobe
   always_comb begin
      busy_in = busy_ff;
      if (query_go) begin
         busy_in = 1'b1;
      end else if (rsp_strobe) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

   // Configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         monitor_count_ff <= '0;
         wrap_h_ff        <= 1'b1;
         wrap_v_ff        <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MONITOR_COUNT: monitor_count_ff <= pwdata[COUNT_W-1:0];
            CSR_WRAP_H:        wrap_h_ff        <= pwdata[0];
            CSR_WRAP_V:        wrap_v_ff        <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_MONITOR_COUNT: prdata = CSR_DATA_W'(monitor_count_ff);
         CSR_WRAP_H:        prdata = CSR_DATA_W'(wrap_h_ff);
         CSR_WRAP_V:        prdata = CSR_DATA_W'(wrap_v_ff);
         default:           prdata = '0;
      endcase
   end

   // Coordinates cast to the internal width
   assign ld_left   = CW'(req_rect_left);
   assign ld_top    = CW'(req_rect_top);
   assign ld_right  = CW'(req_rect_right);
   assign ld_bottom = CW'(req_rect_bottom);

   // Head of the chain: a fresh query with no coverage yet
   assign tok_chain[0]    = '{valid: query_go, row_hit: 1'b0, col_hit: 1'b0};
   assign x_chain[0]      = CW'(req_pointer_x);
   assign y_chain[0]      = CW'(req_pointer_y);
   assign row_lo_chain[0] = '0;
   assign row_hi_chain[0] = '0;
   assign col_lo_chain[0] = '0;
   assign col_hi_chain[0] = '0;

   // Monitor cell chain
   for (genvar i = 0; i < MONITOR_SLOTS; i++) begin : g_cell
      logic cell_load, cell_active;

      assign cell_load   = load_go && (32'(req_slot) == 32'(i));
      assign cell_active = 32'(monitor_count_ff) > 32'(i);

      pewm_cell #(
         .COORD_W (CW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .load_en     (cell_load),
         .load_left   (ld_left),
         .load_top    (ld_top),
         .load_right  (ld_right),
         .load_bottom (ld_bottom),
         .active      (cell_active),
         .up_tok      (tok_chain[i]),
         .up_x        (x_chain[i]),
         .up_y        (y_chain[i]),
         .up_row_lo   (row_lo_chain[i]),
         .up_row_hi   (row_hi_chain[i]),
         .up_col_lo   (col_lo_chain[i]),
         .up_col_hi   (col_hi_chain[i]),
         .dn_tok      (tok_chain[i+1]),
         .dn_x        (x_chain[i+1]),
         .dn_y        (y_chain[i+1]),
         .dn_row_lo   (row_lo_chain[i+1]),
         .dn_row_hi   (row_hi_chain[i+1]),
         .dn_col_lo   (col_lo_chain[i+1]),
         .dn_col_hi   (col_hi_chain[i+1])
      );
   end

   // Edge compare and result register
   pewm_wrap #(
      .COORD_W (CW)
   ) u_wrap (
      .clock      (clock),
      .reset      (reset),
      .wrap_h     (wrap_h_ff),
      .wrap_v     (wrap_v_ff),
      .tok        (tok_chain[MONITOR_SLOTS]),
      .x          (x_chain[MONITOR_SLOTS]),
      .y          (y_chain[MONITOR_SLOTS]),
      .row_lo     (row_lo_chain[MONITOR_SLOTS]),
      .row_hi     (row_hi_chain[MONITOR_SLOTS]),
      .col_lo     (col_lo_chain[MONITOR_SLOTS]),
      .col_hi     (col_hi_chain[MONITOR_SLOTS]),
      .strobe     (rsp_strobe),
      .mapped_x   (rsp_mapped_x),
      .mapped_y   (rsp_mapped_y),
      .wrap_count (rsp_wrap_count)
   );

endmodule
